// ===== hdl/sirt_pkg.sv =====
// Shared types, constants and helper functions for the signed integer
// to radix text converter. No dependencies; imported by every module.
`default_nettype none

package sirt_pkg;

    // field and register widths
    localparam int CHAR_W        = 8;
    localparam int COUNT_W       = 6;
    localparam int DIGIT_W       = 4;
    localparam int RADIX_W       = 5;
    localparam int ALPHA_W       = 64;
    localparam int CFG_DATA_W    = 64;
    localparam int REG_INDEX_W   = 2;
    localparam int BITS_PER_STEP = 8;

    // fixed characters and limits
    localparam logic [CHAR_W-1:0]  MINUS_CHAR = 8'h2D;
    localparam logic [RADIX_W-1:0] RADIX_MIN  = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 5'd16;

    // register reset values
    localparam logic [RADIX_W-1:0] RADIX_RST    = 5'd10;
    localparam logic [ALPHA_W-1:0] ALPHA_LO_RST = 64'h3736353433323130;
    localparam logic [ALPHA_W-1:0] ALPHA_HI_RST = 64'h4645444342413938;

    // configuration register indexes
    typedef enum logic [REG_INDEX_W-1:0] {
        REG_RADIX    = 2'd0,
        REG_ALPHA_LO = 2'd1,
        REG_ALPHA_HI = 2'd2
    } reg_index_t;

    // divider control from the sequencer
    typedef struct packed {
        logic               start;
        logic [RADIX_W-1:0] radix;
    } div_ctl_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIGIT_W-1:0] remainder;
    } div_stat_t;

    // clamp the radix register into 2..16
    function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN)
            res = RADIX_MIN;
        else if (r > RADIX_MAX)
            res = RADIX_MAX;
        return res;
    endfunction

    // map one digit through the 16-entry alphabet
    function automatic logic [CHAR_W-1:0] digit_char(
        input logic [ALPHA_W-1:0] lo,
        input logic [ALPHA_W-1:0] hi,
        input logic [DIGIT_W-1:0] d
    );
        logic [5:0] ofs;
        logic [CHAR_W-1:0] ch;
        ofs = {d[2:0], 3'b000};
        if (d[3])
            ch = hi[ofs +: CHAR_W];
        else
            ch = lo[ofs +: CHAR_W];
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sirt_front.sv =====
// Front end: takes input beats, splits sign and magnitude, and holds
// them in a two-entry queue for the back end. Depends on sirt_pkg.
`default_nettype none

module sirt_front #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [VALUE_BITS-1:0] value,
    output logic                       q_valid,
    input  wire logic                  q_ready,
    output logic                       q_neg,
    output logic [VALUE_BITS-1:0]      q_mag
);
    import sirt_pkg::*;

    localparam int DEPTH = 2;

    logic                  ent_neg_reg [DEPTH];
    logic [VALUE_BITS-1:0] ent_mag_reg [DEPTH];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            count_reg, count_next;
    logic                  push, pop;
    logic                  in_neg;
    logic [VALUE_BITS-1:0] in_mag;

    // sign and full-width magnitude, most negative value fits unsigned
    assign in_neg = value[VALUE_BITS-1];
    assign in_mag = in_neg ? (~value + VALUE_BITS'(1)) : value;

    assign in_ready = (count_reg != 2'(DEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_neg    = ent_neg_reg[rd_ptr_reg];
    assign q_mag    = ent_mag_reg[rd_ptr_reg];

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_neg_reg[wr_ptr_reg] <= in_neg;
            ent_mag_reg[wr_ptr_reg] <= in_mag;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sirt_div.sv =====
// Iterative divider by a small radix: eight restoring steps per cycle,
// yields quotient and remainder digit. Depends on sirt_pkg.
`default_nettype none

module sirt_div #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sirt_pkg::div_ctl_t    ctl,
    input  wire logic [VALUE_BITS-1:0] dividend,
    output sirt_pkg::div_stat_t        stat,
    output logic [VALUE_BITS-1:0]      quotient
);
    import sirt_pkg::*;

    localparam int DIV_W  = ((VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
    localparam int STEPS  = DIV_W / BITS_PER_STEP;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [DIV_W-1:0]   work_reg, work_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [RADIX_W-1:0] radix_reg;
    logic [STEP_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               last_step;

    // eight shift-subtract steps on the top bits of the work word
    always_comb
    begin
        logic [RADIX_W-1:0] trial;
        logic               ge;
        work_next = work_reg;
        rem_next  = rem_reg;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            trial     = {rem_next, work_next[DIV_W-1]};
            ge        = (trial >= radix_reg);
            rem_next  = ge ? DIGIT_W'(trial - radix_reg) : DIGIT_W'(trial);
            work_next = {work_next[DIV_W-2:0], ge};
        end
    end

    assign last_step = (cnt_reg == STEP_W'(STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg  <= '0;
            rem_reg   <= '0;
            radix_reg <= RADIX_MIN;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                work_reg  <= DIV_W'(dividend);
                rem_reg   <= '0;
                radix_reg <= ctl.radix;
                cnt_reg   <= '0;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                work_reg <= work_next;
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg + STEP_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy      = busy_reg;
    assign stat.done      = done_reg;
    assign stat.remainder = rem_reg;
    assign quotient       = work_reg[VALUE_BITS-1:0];

endmodule

`default_nettype wire

// ===== hdl/sirt_back.sv =====
// Back end: drives the divider, stacks the digits, then pops them out
// through the alphabet with a leading minus sign. Depends on sirt_pkg.
`default_nettype none

module sirt_back #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             q_valid,
    output logic                                  q_ready,
    input  wire logic                             q_neg,
    input  wire logic [VALUE_BITS-1:0]            q_mag,
    input  wire logic [sirt_pkg::RADIX_W-1:0]     radix_eff,
    input  wire logic [sirt_pkg::ALPHA_W-1:0]     alpha_lo,
    input  wire logic [sirt_pkg::ALPHA_W-1:0]     alpha_hi,
    output sirt_pkg::div_ctl_t                    div_ctl,
    output logic [VALUE_BITS-1:0]                 div_dividend,
    input  wire sirt_pkg::div_stat_t              div_stat,
    input  wire logic [VALUE_BITS-1:0]            div_quot,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [sirt_pkg::CHAR_W-1:0]           character,
    output logic                                  last,
    output logic [sirt_pkg::COUNT_W-1:0]          char_count
);
    import sirt_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_LOAD
    } state_t;

    state_t             state_reg;
    logic               neg_reg;
    logic               sign_pend_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   ptr_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [DIGIT_W-1:0] digit_stack [MAX_DIGITS];
    logic [DIGIT_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]   n_inc;
    logic [CNT_W-1:0]   ptr_m1;
    logic [CNT_W:0]     total_full;
    logic               more;
    logic               slot_free;
    logic               ptr_last;
    logic               digit_done;
    logic               sign_fire;
    logic               load_fire;

    assign n_inc      = n_reg + CNT_W'(1);
    assign ptr_m1     = ptr_reg - CNT_W'(1);
    assign total_full = {1'b0, n_reg} + (CNT_W + 1)'(neg_reg);
    assign digit_done = (state_reg == ST_DIV) && div_stat.done;
    assign more       = (div_quot != '0) && (n_inc < CNT_W'(MAX_DIGITS));
    assign slot_free  = !out_valid_reg || out_ready;
    assign ptr_last   = (ptr_reg == CNT_W'(1));

    // minus sign goes out as soon as the output slot is free, digits after it
    assign sign_fire  = sign_pend_reg && slot_free && (state_reg != ST_IDLE);
    assign load_fire  = (state_reg == ST_LOAD) && slot_free && !sign_pend_reg;

    // divider hookup: first digit from the queue, later ones from the quotient
    assign q_ready       = (state_reg == ST_IDLE);
    assign div_ctl.start = ((state_reg == ST_IDLE) && q_valid) || (digit_done && more);
    assign div_ctl.radix = radix_eff;
    assign div_dividend  = (state_reg == ST_IDLE) ? q_mag : div_quot;

    // digit stack write
    always_ff @(posedge clk)
    begin
        if (digit_done)
            digit_stack[n_reg[IDX_W-1:0]] <= div_stat.remainder;
    end

    // digit stack registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= digit_stack[ptr_m1[IDX_W-1:0]];
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            neg_reg       <= 1'b0;
            sign_pend_reg <= 1'b0;
            n_reg         <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            // output beat loads on a sign or digit, clears once taken
            if (sign_fire || load_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        neg_reg       <= q_neg;
                        sign_pend_reg <= q_neg;
                        n_reg         <= '0;
                        state_reg     <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        n_reg <= n_inc;
                        if (!more)
                        begin
                            ptr_reg   <= n_inc;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    if (load_fire)
                    begin
                        char_reg      <= digit_char(alpha_lo, alpha_hi, rd_data_reg);
                        last_reg      <= ptr_last;
                        count_reg     <= ptr_last ? COUNT_W'(total_full) : '0;
                        ptr_reg       <= ptr_m1;
                        state_reg     <= ptr_last ? ST_IDLE : ST_READ;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // minus sign beat
            if (sign_fire)
            begin
                char_reg      <= MINUS_CHAR;
                last_reg      <= 1'b0;
                count_reg     <= '0;
                sign_pend_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign character  = char_reg;
    assign last       = last_reg;
    assign char_count = count_reg;

endmodule

`default_nettype wire

// ===== hdl/signed_integer_to_radix_text_top.sv =====
// Top level of the signed integer to radix text converter: configuration
// registers, front end with queue, divider and back end. Depends on sirt_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/value) takes one signed value per beat.
//   Output channel (out_valid/out_ready/character/last/char_count) gives one
//   ASCII character per beat, most significant digit first, with a minus
//   sign ahead of negative values. last marks the final beat of a value and
//   char_count then holds the number of characters, sign included.
//   Configuration: wr_en/wr_index/wr_data write radix (0), alphabet_low (1)
//   and alphabet_high (2); write only while the block is idle.
// Timing:
//   The divider yields eight quotient bits per cycle and one remainder digit
//   per division, restarted on the quotient until it reaches zero or the stack
//   is full; each character then passes through the registered digit stack
//   read (ST_READ, then ST_LOAD).
//   A two-entry queue takes new values while the back end works.
// Reset clears the queue, the sequencer and the output register, and loads
// radix 10 and the alphabet "0123456789ABCDEF". No clearing pass is needed.
// A stalled receiver holds the current beat; the back end waits, and input
// beats are taken until the queue is full.
`default_nettype none

module signed_integer_to_radix_text_top #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [VALUE_BITS-1:0]                 value,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [sirt_pkg::CHAR_W-1:0]                character,
    output logic                                       last,
    output logic [sirt_pkg::COUNT_W-1:0]               char_count,
    input  wire logic                                  wr_en,
    input  wire logic [sirt_pkg::REG_INDEX_W-1:0]      wr_index,
    input  wire logic [sirt_pkg::CFG_DATA_W-1:0]       wr_data
);
    import sirt_pkg::*;

    logic [RADIX_W-1:0]    radix_reg;
    logic [ALPHA_W-1:0]    alpha_lo_reg;
    logic [ALPHA_W-1:0]    alpha_hi_reg;
    logic [RADIX_W-1:0]    radix_eff;

    logic                  q_valid;
    logic                  q_ready;
    logic                  q_neg;
    logic [VALUE_BITS-1:0] q_mag;

    div_ctl_t              div_ctl;
    div_stat_t             div_stat;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_quot;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg    <= RADIX_RST;
            alpha_lo_reg <= ALPHA_LO_RST;
            alpha_hi_reg <= ALPHA_HI_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_RADIX:    radix_reg    <= wr_data[RADIX_W-1:0];
                REG_ALPHA_LO: alpha_lo_reg <= wr_data[ALPHA_W-1:0];
                REG_ALPHA_HI: alpha_hi_reg <= wr_data[ALPHA_W-1:0];
                default:      ;
            endcase
        end
    end

    assign radix_eff = effective_radix(radix_reg);

    // sign split and queue
    sirt_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .value    (value),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_neg    (q_neg),
        .q_mag    (q_mag)
    );

    // radix divider
    sirt_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // digit stack and character output
    sirt_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_neg        (q_neg),
        .q_mag        (q_mag),
        .radix_eff    (radix_eff),
        .alpha_lo     (alpha_lo_reg),
        .alpha_hi     (alpha_hi_reg),
        .div_ctl      (div_ctl),
        .div_dividend (div_dividend),
        .div_stat     (div_stat),
        .div_quot     (div_quot),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .character    (character),
        .last         (last),
        .char_count   (char_count)
    );

`ifndef SYNTHESIS
    // count only rides on the final beat of a value
    a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (char_count == '0))
        else $error("char_count nonzero on a beat that is not last");

    // the divider is never restarted while it is still working
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.start |-> !div_stat.busy)
        else $error("divider started while busy");

    // a digit completes in a single-cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |=> !div_stat.done)
        else $error("divider done held for more than one cycle");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench for signed_integer_to_radix_text_top: directed rows, then random phases
// over several radix and alphabet settings, checked beat by beat against typed or predicted text.
// Depends on sirt_pkg and the top level RTL only.

module tb;

    import sirt_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_VALUES = 49;
    localparam int SETTLE       = 250;

    // one expected output beat
    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic               is_last;
        logic [COUNT_W-1:0] count;
    } text_beat_t;

    // one directed row: radix register, input value, typed text (empty means predicted)
    typedef struct {
        logic [RADIX_W-1:0] radix_reg;
        logic [31:0]        val;
        string              text;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [31:0]            value = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [CHAR_W-1:0]      character;
    logic                   last;
    logic [COUNT_W-1:0]     char_count;
    logic                   wr_en = 1'b0;
    logic [REG_INDEX_W-1:0] wr_index = '0;
    logic [CFG_DATA_W-1:0]  wr_data = '0;

    // predictor copy of the configuration
    logic [RADIX_W-1:0] cfg_radix    = RADIX_RST;
    logic [ALPHA_W-1:0] cfg_alpha_lo = ALPHA_LO_RST;
    logic [ALPHA_W-1:0] cfg_alpha_hi = ALPHA_HI_RST;

    text_beat_t expected_chars[$];
    stim_row_t  directed_rows[$];
    int         fail_count = 0;
    bit         idle_on = 1'b1;
    bit         hold_req = 1'b0;

    signed_integer_to_radix_text_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .character  (character),
        .last       (last),
        .char_count (char_count),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    always #10 clk = ~clk;

    // alphabet lookup over both registers
    function automatic logic [CHAR_W-1:0] alpha_char(input logic [3:0] d);
        logic [2*ALPHA_W-1:0] glyphs;
        glyphs = {cfg_alpha_hi, cfg_alpha_lo};
        return glyphs[{d, 3'b000} +: CHAR_W];
    endfunction

    function automatic int clamped_radix();
        int r;
        r = cfg_radix;
        if (r < 2)
            r = 2;
        else if (r > 16)
            r = 16;
        return r;
    endfunction

    // repeated division, then sign and digits most significant first
    function automatic void predict_text(input logic [31:0] v);
        logic        neg;
        logic [31:0] mag;
        logic [31:0] base;
        logic [3:0]  digits [32];
        int          n;
        int          total;
        text_beat_t  beat;
        neg = v[31];
        mag = neg ? (~v + 32'd1) : v;
        base = clamped_radix();
        n = 0;
        do
        begin
            digits[n] = 4'(mag % base);
            mag = mag / base;
            n++;
        end
        while (mag != 0 && n < 32);
        total = n + (neg ? 1 : 0);
        for (int k = 0; k < total; k++)
        begin
            if (neg && k == 0)
                beat.ch = MINUS_CHAR;
            else
                beat.ch = alpha_char(digits[total - 1 - k]);
            beat.is_last = (k == total - 1);
            beat.count = beat.is_last ? COUNT_W'(total) : '0;
            expected_chars.push_back(beat);
        end
    endfunction

    // typed text straight into the expectation queue
    function automatic void expect_typed(input string s);
        text_beat_t beat;
        for (int k = 0; k < s.len(); k++)
        begin
            beat.ch = s[k];
            beat.is_last = (k == s.len() - 1);
            beat.count = beat.is_last ? COUNT_W'(s.len()) : '0;
            expected_chars.push_back(beat);
        end
    endfunction

    function automatic void add_row(input logic [RADIX_W-1:0] r, input logic [31:0] v,
                                    input string s);
        stim_row_t row;
        row.radix_reg = r;
        row.val = v;
        row.text = s;
        directed_rows.push_back(row);
    endfunction

    // mix of full range, short values, extremes and digit count boundaries
    function automatic logic [31:0] random_value();
        logic [63:0] pw;
        logic [31:0] v;
        int          base;
        int          k;
        base = clamped_radix();
        case ($urandom_range(0, 7))
            0, 1, 2: v = $urandom;
            3: v = $urandom >> $urandom_range(1, 31);
            4: v = $urandom_range(0, 64) - 32;
            5:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'h0000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h8000_0000;
                    3: v = 32'h8000_0001;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default:
            begin
                pw = 64'd1;
                k = $urandom_range(1, 31);
                repeat (k)
                    if (pw * base <= 64'h8000_0000)
                        pw = pw * base;
                v = pw[31:0] - $urandom_range(0, 1);
            end
        endcase
        if ($urandom_range(0, 3) == 0)
            v = -v;
        return v;
    endfunction

    // compare one output beat with the oldest expectation
    function automatic void check_beat(input logic [CHAR_W-1:0] ch, input logic fin,
                                       input logic [COUNT_W-1:0] cnt);
        text_beat_t want;
        if (expected_chars.size() == 0)
        begin
            $error("unexpected output beat: character %h last %b char_count %0d",
                   ch, fin, cnt);
            fail_count++;
            return;
        end
        want = expected_chars.pop_front();
        if (ch !== want.ch)
        begin
            $error("character: expected %h, got %h", want.ch, ch);
            fail_count++;
        end
        if (fin !== want.is_last)
        begin
            $error("last: expected %b, got %b", want.is_last, fin);
            fail_count++;
        end
        if (cnt !== want.count)
        begin
            $error("char_count: expected %0d, got %0d", want.count, cnt);
            fail_count++;
        end
    endfunction

    // write all three registers, predictor follows at each edge
    task automatic set_config(input logic [RADIX_W-1:0] r, input logic [ALPHA_W-1:0] lo,
                              input logic [ALPHA_W-1:0] hi);
        logic [CFG_DATA_W-1:0] junk;
        junk = {$urandom, $urandom};
        wr_en <= 1'b1;
        wr_index <= REG_RADIX;
        wr_data <= {junk[CFG_DATA_W-1:RADIX_W], r};
        @(posedge clk);
        cfg_radix = r;
        wr_index <= REG_ALPHA_LO;
        wr_data <= lo;
        @(posedge clk);
        cfg_alpha_lo = lo;
        wr_index <= REG_ALPHA_HI;
        wr_data <= hi;
        @(posedge clk);
        cfg_alpha_hi = hi;
        wr_en <= 1'b0;
    endtask

    // offer one input beat after a random gap, return at the accepting edge
    task automatic send_value(input logic [31:0] v);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop offering and wait for every expected beat
    task automatic drain_text();
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // output side: random stalls, one long hold on request
    initial
    begin : receiver
        int stall;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                stall = idle_on ? $urandom_range(0, 9) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            check_beat(character, last, char_count);
        end
    end

    // watchdog on cycles with no beat on either channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("signed_integer_to_radix_text_top verification failed");
        $finish;
    end

    initial
    begin : main_seq
        logic [RADIX_W-1:0] r;
        logic [ALPHA_W-1:0] lo;
        logic [ALPHA_W-1:0] hi;

        // reset settings, decimal
        add_row(5'd10, 32'd0, "0");
        add_row(5'd10, 32'd1, "1");
        add_row(5'd10, 32'hFFFF_FFFF, "-1");
        add_row(5'd10, 32'd9, "9");
        add_row(5'd10, 32'd10, "10");
        add_row(5'd10, -32'sd10, "-10");
        add_row(5'd10, 32'h7FFF_FFFF, "2147483647");
        add_row(5'd10, 32'h8000_0000, "-2147483648");
        add_row(5'd10, 32'd999999999, "999999999");
        add_row(5'd10, 32'd1000000000, "1000000000");
        add_row(5'd10, -32'sd987654321, "-987654321");
        add_row(5'd10, 32'd12345, "");
        // hex
        add_row(5'd16, 32'h7FFF_FFFF, "7FFFFFFF");
        add_row(5'd16, 32'hFFFF_FFFF, "-1");
        add_row(5'd16, 32'hDEAD_BEEF, "-21524111");
        add_row(5'd16, 32'd255, "FF");
        // binary: longest text, sign plus 32 digits
        add_row(5'd2, 32'h8000_0000,
                {"-1", "00000000", "00000000", "00000000", "0000000"});
        add_row(5'd2, 32'h7FFF_FFFF, {"11111111", "11111111", "11111111", "1111111"});
        add_row(5'd2, 32'd0, "0");
        add_row(5'd2, 32'd5, "101");
        // radix clamped low and high
        add_row(5'd0, 32'd5, "101");
        add_row(5'd1, -32'sd6, "-110");
        add_row(5'd17, 32'd255, "FF");
        add_row(5'd31, -32'sd255, "-FF");
        add_row(5'd7, 32'd123456, "");

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, reset alphabet throughout
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].radix_reg != cfg_radix)
            begin
                drain_text();
                set_config(directed_rows[i].radix_reg, cfg_alpha_lo, cfg_alpha_hi);
            end
            send_value(directed_rows[i].val);
            if (directed_rows[i].text.len() == 0)
                predict_text(directed_rows[i].val);
            else
                expect_typed(directed_rows[i].text);
        end

        // random phases over several settings
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain_text();
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            idle_on = 1'b1;
            case (p)
                0:
                begin
                    r = 5'd16;
                    lo = ALPHA_LO_RST;
                    hi = ALPHA_HI_RST;
                end
                1:
                begin
                    r = 5'd2;
                    idle_on = 1'b0;
                end
                2:
                begin
                    r = 5'($urandom_range(3, 15));
                    lo = '0;
                    hi = '1;
                end
                3:
                begin
                    r = 5'd10;
                    lo = ALPHA_LO_RST;
                    hi = ALPHA_HI_RST;
                    idle_on = 1'b0;
                end
                4: r = 5'd0;
                5:
                begin
                    r = 5'd31;
                    lo = '1;
                    hi = '0;
                end
                6:
                begin
                    r = 5'($urandom_range(0, 31));
                    idle_on = 1'b0;
                end
                default: r = 5'($urandom_range(2, 16));
            endcase
            set_config(r, lo, hi);
            // receiver holds off while beats keep coming, input stalls once the queue fills
            if (p == 3)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_VALUES; n++)
            begin
                logic [31:0] v;
                v = random_value();
                // sender pauses until the output side has caught up
                if (p == 4 && n == PHASE_VALUES / 2)
                    drain_text();
                send_value(v);
                predict_text(v);
            end
        end

        drain_text();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("signed_integer_to_radix_text_top verification clean");
        else
            $display("signed_integer_to_radix_text_top verification failed");
        $finish;
    end

endmodule
